>>> hw/rtl/kmlt_pkg.sv
// Shared types, codes and helper functions of the k-means trainer.
`default_nettype none
package kmlt_pkg;

	localparam int DEF_MAX_POINTS   = 1024;
	localparam int DEF_MAX_CLUSTERS = 32;
	localparam int DEF_MAX_DIM      = 32;
	localparam int DEF_FEATURE_BITS = 16;

	// Register values after reset.
	localparam int RST_NUM_CLUSTERS   = 8;
	localparam int RST_NUM_POINTS     = 1024;
	localparam int RST_DIMENSION      = 32;
	localparam int RST_MAX_ITERATIONS = 10;

	// Fixed field widths of the ports.
	localparam int KIND_W    = 3;
	localparam int INDEX_W   = 10;
	localparam int ELEMENT_W = 5;
	localparam int CLUSTER_W = 6;
	localparam int REASSIGN_W = 11;
	localparam int ITER_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_POINT    = 3'd0,
		KIND_LOAD_CENTROID = 3'd1,
		KIND_RUN           = 3'd2,
		KIND_READ_MEMBER   = 3'd3,
		KIND_READ_CENTROID = 3'd4
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIMENSION      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FROZEN         = 3'd4;

	// Status of the training engine toward the top level.
	typedef struct packed {
		logic busy;
		logic done;
		logic fail;
	} eng_stat_t;

	// Number of bits to index n things, never less than one.
	function automatic int bits_for(input int n);
		int r;
		r = (n <= 2) ? 1 : $clog2(n);
		return r;
	endfunction

	// Saturate a register value into [1, hi].
	function automatic int clamp_reg(input int v, input int hi);
		int r;
		r = (v < 1) ? 1 : ((v > hi) ? hi : v);
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/kmlt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module kmlt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [kmlt_pkg::bits_for(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [kmlt_pkg::bits_for(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/kmlt_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
`default_nettype none
module kmlt_div #(
	parameter int NW = 26,
	parameter int DW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);

	localparam int CNT_W = kmlt_pkg::bits_for(NW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic             neg_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [DW:0]      rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NW-1];
			quo_q <= dividend[NW-1] ? (~dividend + NW'(1)) : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? DW'(rem_sh - {1'b0, div_q}) : DW'(rem_sh);
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + NW'(1)) : quo_q;

endmodule
`default_nettype wire

>>> hw/rtl/kmlt_core.sv
// Training engine: stores, distance pipeline, accumulation and centroid update sequencer.
`default_nettype none
module kmlt_core #(
	parameter int MAX_POINTS   = kmlt_pkg::DEF_MAX_POINTS,
	parameter int MAX_CLUSTERS = kmlt_pkg::DEF_MAX_CLUSTERS,
	parameter int MAX_DIM      = kmlt_pkg::DEF_MAX_DIM,
	parameter int FEATURE_BITS = kmlt_pkg::DEF_FEATURE_BITS,
	localparam int PW   = kmlt_pkg::bits_for(MAX_POINTS),
	localparam int PCW  = kmlt_pkg::bits_for(MAX_POINTS + 1),
	localparam int KW   = kmlt_pkg::bits_for(MAX_CLUSTERS + 1),
	localparam int DW   = kmlt_pkg::bits_for(MAX_DIM + 1),
	localparam int PAW  = kmlt_pkg::bits_for(MAX_POINTS * MAX_DIM),
	localparam int CAW  = kmlt_pkg::bits_for(MAX_CLUSTERS * MAX_DIM),
	localparam int FB   = FEATURE_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [KW-1:0]       k_eff,
	input  wire logic [PCW-1:0]      n_eff,
	input  wire logic [DW-1:0]       d_eff,
	input  wire logic [7:0]          max_it,
	input  wire logic                frozen,
	input  wire logic                run_start,
	output kmlt_pkg::eng_stat_t      stat,
	output logic [PCW-1:0]           reassigned,
	output logic [7:0]               iterations,
	input  wire logic                h_pt_we,
	input  wire logic [PAW-1:0]      h_pt_addr,
	input  wire logic [FB-1:0]       h_pt_wdata,
	input  wire logic                h_ce_we,
	input  wire logic [CAW-1:0]      h_ce_addr,
	input  wire logic [FB-1:0]       h_ce_wdata,
	input  wire logic [CAW-1:0]      h_ce_raddr,
	input  wire logic [PW-1:0]       h_mem_raddr,
	output logic [FB-1:0]            h_ce_rdata,
	output logic [KW-1:0]            h_mem_rdata
);

	localparam int CW    = kmlt_pkg::bits_for(MAX_CLUSTERS);
	localparam int EW    = kmlt_pkg::bits_for(MAX_DIM);
	localparam int SUMW  = FB + kmlt_pkg::bits_for(MAX_POINTS);
	localparam int SQW   = 2 * FB;
	localparam int DISTW = SQW + DW;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_CLR     = 13'b0000000000010,
		S_AS_RUN  = 13'b0000000000100,
		S_AS_WAIT = 13'b0000000001000,
		S_AC_CLR  = 13'b0000000010000,
		S_AC_M    = 13'b0000000100000,
		S_AC_M2   = 13'b0000001000000,
		S_AC_E    = 13'b0000010000000,
		S_AC_W    = 13'b0000100000000,
		S_UP_E    = 13'b0001000000000,
		S_UP_S    = 13'b0010000000000,
		S_UP_W    = 13'b0100000000000,
		S_NEXT    = 13'b1000000000000
	} state_t;

	state_t          state_q;
	logic [PW-1:0]   p_q;
	logic [CW-1:0]   c_q;
	logic [EW-1:0]   e_q;
	logic [7:0]      it_q;
	logic [PCW-1:0]  moved_q;
	logic [PCW-1:0]  reassign_q;
	logic [7:0]      iter_q;
	logic            done_q;
	logic            fail_q;
	logic            pt_done_q;

	logic            v_s1, fe_s1, le_s1, lc_s1;
	logic [CW-1:0]   c_s1;
	logic            v_s2, fe_s2, le_s2, lc_s2;
	logic [CW-1:0]   c_s2;
	logic [SQW-1:0]  sq_s2;
	logic [DISTW-1:0] acc_q, best_d_q, acc_sum;
	logic [CW-1:0]   best_c_q;
	logic            av_s1;
	logic [CAW-1:0]  aaddr_s1;
	logic [CW-1:0]   m_q;
	logic            zero_q;

	logic            idle, e_last, c_last, p_last, clr_last, changed;
	logic [PCW-1:0]  moved_n;
	logic [7:0]      it_n;
	logic [CAW-1:0]  ce_eng_addr, sm_acc_addr;

	logic [PAW-1:0]  pt_waddr, pt_raddr;
	logic [FB-1:0]   pt_wdata, pt_rdata;
	logic            pt_we;
	logic [CAW-1:0]  ce_waddr, ce_raddr;
	logic [FB-1:0]   ce_wdata, ce_rdata;
	logic            ce_we;
	logic [CAW-1:0]  sum_waddr, sum_raddr;
	logic [SUMW-1:0] sum_wdata, sum_rdata;
	logic            sum_we;
	logic [CW-1:0]   cnt_waddr, cnt_raddr;
	logic [PCW-1:0]  cnt_wdata, cnt_rdata;
	logic            cnt_we;
	logic [PW-1:0]   mem_waddr, mem_raddr;
	logic [KW-1:0]   mem_wdata, mem_rdata;
	logic            mem_we;

	logic signed [FB:0]       diff;
	logic signed [2*FB+1:0]   prod;
	logic                     div_done;
	logic [SUMW-1:0]          quot;

	assign idle     = (state_q == S_IDLE);
	assign e_last   = (DW'(e_q) == d_eff - DW'(1));
	assign c_last   = (KW'(c_q) == k_eff - KW'(1));
	assign p_last   = (PCW'(p_q) == n_eff - PCW'(1));
	assign clr_last = (p_q == PW'(MAX_POINTS - 1));
	assign changed  = (mem_rdata != KW'(best_c_q));
	assign moved_n  = moved_q + PCW'(changed);
	assign it_n     = it_q + 8'd1;

	assign ce_eng_addr = CAW'(int'(c_q) * MAX_DIM + int'(e_q));
	assign sm_acc_addr = CAW'(int'(m_q) * MAX_DIM + int'(e_q));

	// Port selection for all stores.
	always_comb begin
		pt_we     = idle && h_pt_we;
		pt_waddr  = h_pt_addr;
		pt_wdata  = h_pt_wdata;
		pt_raddr  = PAW'(int'(p_q) * MAX_DIM + int'(e_q));

		ce_we     = idle ? h_ce_we : ((state_q == S_UP_W) && div_done);
		ce_waddr  = idle ? h_ce_addr : ce_eng_addr;
		ce_wdata  = idle ? h_ce_wdata : (zero_q ? '0 : quot[FB-1:0]);
		ce_raddr  = idle ? h_ce_raddr : ce_eng_addr;

		sum_we    = (state_q == S_AC_CLR) || av_s1;
		sum_waddr = (state_q == S_AC_CLR) ? ce_eng_addr : aaddr_s1;
		sum_wdata = (state_q == S_AC_CLR) ? '0 :
			sum_rdata + {{(SUMW-FB){pt_rdata[FB-1]}}, pt_rdata};
		sum_raddr = (state_q == S_AC_E) ? sm_acc_addr : ce_eng_addr;

		cnt_we    = (state_q == S_AC_CLR) || (state_q == S_AC_W);
		cnt_waddr = (state_q == S_AC_CLR) ? c_q : m_q;
		cnt_wdata = (state_q == S_AC_CLR) ? '0 : cnt_rdata + PCW'(1);
		cnt_raddr = ((state_q == S_UP_E) || (state_q == S_UP_S)) ? c_q : m_q;

		mem_we    = (state_q == S_CLR) || ((state_q == S_AS_WAIT) && pt_done_q);
		mem_waddr = p_q;
		mem_wdata = (state_q == S_CLR) ? k_eff : KW'(best_c_q);
		mem_raddr = idle ? h_mem_raddr : p_q;
	end

	kmlt_ram #(.WIDTH(FB), .DEPTH(MAX_POINTS * MAX_DIM)) u_point_ram (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	kmlt_ram #(.WIDTH(FB), .DEPTH(MAX_CLUSTERS * MAX_DIM)) u_centroid_ram (
		.clk(clk), .we(ce_we), .waddr(ce_waddr), .wdata(ce_wdata),
		.raddr(ce_raddr), .rdata(ce_rdata)
	);

	kmlt_ram #(.WIDTH(SUMW), .DEPTH(MAX_CLUSTERS * MAX_DIM)) u_sum_ram (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.raddr(sum_raddr), .rdata(sum_rdata)
	);

	kmlt_ram #(.WIDTH(PCW), .DEPTH(MAX_CLUSTERS)) u_count_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	kmlt_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_member_ram (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	kmlt_div #(.NW(SUMW), .DW(PCW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_UP_S),
		.dividend(sum_rdata), .divisor(cnt_rdata),
		.done(div_done), .quotient(quot)
	);

	// Distance datapath: difference and square, then accumulate and compare.
	assign diff    = $signed({ce_rdata[FB-1], ce_rdata}) - $signed({pt_rdata[FB-1], pt_rdata});
	assign prod    = diff * diff;
	assign acc_sum = (fe_s2 ? '0 : acc_q) + DISTW'(sq_s2);

	always_ff @(posedge clk) begin
		sq_s2    <= prod[SQW-1:0];
		c_s1     <= c_q;
		c_s2     <= c_s1;
		fe_s2    <= fe_s1;
		le_s2    <= le_s1;
		lc_s2    <= lc_s1;
		aaddr_s1 <= sm_acc_addr;
		if (v_s2) begin
			acc_q <= acc_sum;
			if (le_s2 && ((c_s2 == '0) || (acc_sum < best_d_q))) begin
				best_c_q <= c_s2;
				best_d_q <= acc_sum;
			end
		end
		if (state_q == S_AC_M2) begin
			m_q <= CW'(mem_rdata);
		end
		if (state_q == S_UP_S) begin
			zero_q <= (cnt_rdata == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			p_q        <= '0;
			c_q        <= '0;
			e_q        <= '0;
			it_q       <= '0;
			moved_q    <= '0;
			reassign_q <= '0;
			iter_q     <= '0;
			done_q     <= 1'b0;
			fail_q     <= 1'b0;
			pt_done_q  <= 1'b0;
			v_s1       <= 1'b0;
			fe_s1      <= 1'b0;
			le_s1      <= 1'b0;
			lc_s1      <= 1'b0;
			v_s2       <= 1'b0;
			av_s1      <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			v_s1      <= (state_q == S_AS_RUN);
			fe_s1     <= (e_q == '0);
			le_s1     <= e_last;
			lc_s1     <= c_last;
			v_s2      <= v_s1;
			pt_done_q <= v_s2 && le_s2 && lc_s2;
			av_s1     <= (state_q == S_AC_E);
			case (state_q)
				S_IDLE: begin
					if (run_start) begin
						reassign_q <= '0;
						iter_q     <= '0;
						it_q       <= '0;
						if (int'(n_eff) < int'(k_eff)) begin
							done_q <= 1'b1;
							fail_q <= 1'b1;
						end else begin
							p_q     <= '0;
							state_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					p_q <= p_q + PW'(1);
					if (clr_last) begin
						p_q     <= '0;
						c_q     <= '0;
						e_q     <= '0;
						moved_q <= '0;
						if (max_it == '0) begin
							done_q  <= 1'b1;
							fail_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_AS_RUN;
						end
					end
				end
				S_AS_RUN: begin
					e_q <= e_q + EW'(1);
					if (e_last) begin
						e_q <= '0;
						c_q <= c_q + CW'(1);
						if (c_last) begin
							c_q     <= '0;
							state_q <= S_AS_WAIT;
						end
					end
				end
				S_AS_WAIT: begin
					if (pt_done_q) begin
						moved_q <= moved_n;
						p_q     <= p_q + PW'(1);
						state_q <= S_AS_RUN;
						if (p_last) begin
							it_q       <= it_n;
							iter_q     <= it_n;
							reassign_q <= moved_n;
							c_q        <= '0;
							e_q        <= '0;
							if (moved_n == '0) begin
								done_q  <= 1'b1;
								fail_q  <= 1'b0;
								state_q <= S_IDLE;
							end else if (!frozen) begin
								state_q <= S_AC_CLR;
							end else begin
								state_q <= S_NEXT;
							end
						end
					end
				end
				S_AC_CLR: begin
					e_q <= e_q + EW'(1);
					if (e_last) begin
						e_q <= '0;
						c_q <= c_q + CW'(1);
						if (c_last) begin
							c_q     <= '0;
							p_q     <= '0;
							state_q <= S_AC_M;
						end
					end
				end
				S_AC_M: begin
					state_q <= S_AC_M2;
				end
				S_AC_M2: begin
					e_q     <= '0;
					state_q <= S_AC_E;
				end
				S_AC_E: begin
					e_q <= e_q + EW'(1);
					if (e_last) begin
						e_q     <= '0;
						state_q <= S_AC_W;
					end
				end
				S_AC_W: begin
					p_q     <= p_q + PW'(1);
					state_q <= S_AC_M;
					if (p_last) begin
						c_q     <= '0;
						e_q     <= '0;
						state_q <= S_UP_E;
					end
				end
				S_UP_E: begin
					state_q <= S_UP_S;
				end
				S_UP_S: begin
					state_q <= S_UP_W;
				end
				S_UP_W: begin
					if (div_done) begin
						state_q <= S_UP_E;
						e_q     <= e_q + EW'(1);
						if (e_last) begin
							e_q <= '0;
							c_q <= c_q + CW'(1);
							if (c_last) begin
								c_q     <= '0;
								state_q <= S_NEXT;
							end
						end
					end
				end
				S_NEXT: begin
					p_q     <= '0;
					c_q     <= '0;
					e_q     <= '0;
					moved_q <= '0;
					if (it_q == max_it) begin
						done_q  <= 1'b1;
						fail_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_AS_RUN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.busy   = !idle;
	assign stat.done   = done_q;
	assign stat.fail   = fail_q;
	assign reassigned  = reassign_q;
	assign iterations  = iter_q;
	assign h_ce_rdata  = ce_rdata;
	assign h_mem_rdata = mem_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/kmeans_lloyd_trainer_unit.sv
// Top level of the k-means trainer: stream ports, configuration registers and result register.
`default_nettype none
// The unit trains k-means clusters with Lloyd's algorithm on signed Q7.8 features.
// Load words write one point element or one initial centroid element and give no
// result; read words (membership or centroid element) load the result register in the
// cycle after they are taken. A run word first walks the whole membership memory, one
// entry a cycle, marking every point unassigned. Each iteration then runs the assignment
// pass, where the distance for one point and one centroid streams d element pairs out of
// the point and centroid memories at one pair a cycle through a subtract, square and
// accumulate pipeline, which drains before the membership of the point is written. When
// points moved and centroids are not frozen, the iteration then clears the sums,
// accumulates the members and forms the means, where the mean of each element goes
// through a bit-serial divider of SUMW = FEATURE_BITS + log2(MAX_POINTS) steps; the
// iteration then closes in S_NEXT. A run stops after max_iterations or after the first
// iteration that moves no point, and gives one result word with the status and counts.
// With fewer points than clusters the run ends at once with status 1. The input side
// takes no new word while a result is pending or while a finished result is held and
// not being taken in that same cycle.
module kmeans_lloyd_trainer_unit #(
	parameter int MAX_POINTS   = kmlt_pkg::DEF_MAX_POINTS,
	parameter int MAX_CLUSTERS = kmlt_pkg::DEF_MAX_CLUSTERS,
	parameter int MAX_DIM      = kmlt_pkg::DEF_MAX_DIM,
	parameter int FEATURE_BITS = kmlt_pkg::DEF_FEATURE_BITS,
	localparam int IN_BITS  = kmlt_pkg::INDEX_W + kmlt_pkg::ELEMENT_W + FEATURE_BITS,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 1 + kmlt_pkg::CLUSTER_W + FEATURE_BITS + kmlt_pkg::REASSIGN_W
		+ kmlt_pkg::ITER_W,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// index, element, value (from bit 0 up), zero padded
	input  wire logic [IN_W-1:0]                   s_tdata,
	// kind
	input  wire logic [kmlt_pkg::KIND_W-1:0]       s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// status, cluster, centroid_value, reassigned, iterations_done (from bit 0 up)
	output logic [OUT_W-1:0]                       m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [kmlt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [kmlt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int FB  = FEATURE_BITS;
	localparam int PW  = kmlt_pkg::bits_for(MAX_POINTS);
	localparam int PCW = kmlt_pkg::bits_for(MAX_POINTS + 1);
	localparam int KW  = kmlt_pkg::bits_for(MAX_CLUSTERS + 1);
	localparam int DW  = kmlt_pkg::bits_for(MAX_DIM + 1);
	localparam int PAW = kmlt_pkg::bits_for(MAX_POINTS * MAX_DIM);
	localparam int CAW = kmlt_pkg::bits_for(MAX_CLUSTERS * MAX_DIM);
	localparam int IW  = kmlt_pkg::INDEX_W;
	localparam int EIW = kmlt_pkg::ELEMENT_W;
	// Membership of every point before the first successful run.
	localparam int RESET_K = kmlt_pkg::clamp_reg(kmlt_pkg::RST_NUM_CLUSTERS, MAX_CLUSTERS);

	// Configuration registers.
	logic [5:0]  num_clusters_q;
	logic [10:0] num_points_q;
	logic [5:0]  dimension_q;
	logic [7:0]  max_iterations_q;
	logic        frozen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q   <= 6'(kmlt_pkg::RST_NUM_CLUSTERS);
			num_points_q     <= 11'(kmlt_pkg::RST_NUM_POINTS);
			dimension_q      <= 6'(kmlt_pkg::RST_DIMENSION);
			max_iterations_q <= 8'(kmlt_pkg::RST_MAX_ITERATIONS);
			frozen_q         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				kmlt_pkg::REG_NUM_CLUSTERS:   num_clusters_q   <= cfg_wdata[5:0];
				kmlt_pkg::REG_NUM_POINTS:     num_points_q     <= cfg_wdata;
				kmlt_pkg::REG_DIMENSION:      dimension_q      <= cfg_wdata[5:0];
				kmlt_pkg::REG_MAX_ITERATIONS: max_iterations_q <= cfg_wdata[7:0];
				kmlt_pkg::REG_FROZEN:         frozen_q         <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Effective sizes, saturated into the range the stores support.
	logic [KW-1:0]  k_eff;
	logic [PCW-1:0] n_eff;
	logic [DW-1:0]  d_eff;

	assign k_eff = KW'(kmlt_pkg::clamp_reg(int'(num_clusters_q), MAX_CLUSTERS));
	assign n_eff = PCW'(kmlt_pkg::clamp_reg(int'(num_points_q), MAX_POINTS));
	assign d_eff = DW'(kmlt_pkg::clamp_reg(int'(dimension_q), MAX_DIM));

	// Input word fields.
	kmlt_pkg::kind_t kind;
	logic [IW-1:0]   idx;
	logic [EIW-1:0]  el;
	logic [FB-1:0]   value;
	logic            pt_ok, cl_ok, el_ok, accept;

	assign kind   = kmlt_pkg::kind_t'(s_tuser);
	assign idx    = s_tdata[IW-1:0];
	assign el     = s_tdata[IW+EIW-1:IW];
	assign value  = s_tdata[IW+EIW+FB-1:IW+EIW];
	assign pt_ok  = int'(idx) < MAX_POINTS;
	assign cl_ok  = int'(idx) < MAX_CLUSTERS;
	assign el_ok  = int'(el) < MAX_DIM;
	assign accept = s_tvalid && s_tready;

	// A result-producing word stays pending until its result is captured.
	logic            pend_q;
	kmlt_pkg::kind_t pkind_q;
	logic            pok_q;
	logic            ran_q;
	logic            out_v_q;
	logic            o_status_q;
	logic [kmlt_pkg::CLUSTER_W-1:0]  o_cluster_q;
	logic [FB-1:0]                   o_cval_q;
	logic [kmlt_pkg::REASSIGN_W-1:0] o_reas_q;
	logic [kmlt_pkg::ITER_W-1:0]     o_iter_q;

	kmlt_pkg::eng_stat_t stat;
	logic [PCW-1:0]      reassigned;
	logic [7:0]          iterations;
	logic [FB-1:0]       ce_rdata;
	logic [KW-1:0]       mem_rdata;
	logic [KW-1:0]       member_val;
	logic                cap, gives_result;

	assign s_tready = !pend_q && (!out_v_q || m_tready);
	assign gives_result = (kind == kmlt_pkg::KIND_RUN) || (kind == kmlt_pkg::KIND_READ_MEMBER)
		|| (kind == kmlt_pkg::KIND_READ_CENTROID);
	assign cap = pend_q && ((pkind_q != kmlt_pkg::KIND_RUN) || stat.done);
	assign member_val = !pok_q ? k_eff : (ran_q ? mem_rdata : KW'(RESET_K));

	kmlt_core #(
		.MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS),
		.MAX_DIM(MAX_DIM), .FEATURE_BITS(FEATURE_BITS)
	) u_core (
		.clk(clk), .arst_n(arst_n),
		.k_eff(k_eff), .n_eff(n_eff), .d_eff(d_eff),
		.max_it(max_iterations_q), .frozen(frozen_q),
		.run_start(accept && (kind == kmlt_pkg::KIND_RUN)),
		.stat(stat), .reassigned(reassigned), .iterations(iterations),
		.h_pt_we(accept && (kind == kmlt_pkg::KIND_LOAD_POINT) && pt_ok && el_ok),
		.h_pt_addr(PAW'(int'(idx) * MAX_DIM + int'(el))),
		.h_pt_wdata(value),
		.h_ce_we(accept && (kind == kmlt_pkg::KIND_LOAD_CENTROID) && cl_ok && el_ok),
		.h_ce_addr(CAW'(int'(idx) * MAX_DIM + int'(el))),
		.h_ce_wdata(value),
		.h_ce_raddr(CAW'(int'(idx) * MAX_DIM + int'(el))),
		.h_mem_raddr(PW'(idx)),
		.h_ce_rdata(ce_rdata),
		.h_mem_rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			pkind_q <= kmlt_pkg::KIND_LOAD_POINT;
			pok_q   <= 1'b0;
			ran_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (cap) begin
				pend_q  <= 1'b0;
				out_v_q <= 1'b1;
			end
			if (accept && gives_result) begin
				pend_q  <= 1'b1;
				pkind_q <= kind;
				pok_q   <= (kind == kmlt_pkg::KIND_READ_MEMBER) ? pt_ok : (cl_ok && el_ok);
			end
			if (accept && (kind == kmlt_pkg::KIND_RUN) && (int'(n_eff) >= int'(k_eff))) begin
				ran_q <= 1'b1;
			end
		end
	end

	// Result fields; only read words carry a cluster or a centroid value.
	always_ff @(posedge clk) begin
		if (cap) begin
			o_status_q  <= (pkind_q == kmlt_pkg::KIND_RUN) && stat.fail;
			o_cluster_q <= (pkind_q == kmlt_pkg::KIND_READ_MEMBER) ?
				kmlt_pkg::CLUSTER_W'(member_val) : '0;
			o_cval_q    <= ((pkind_q == kmlt_pkg::KIND_READ_CENTROID) && pok_q) ? ce_rdata : '0;
			o_reas_q    <= kmlt_pkg::REASSIGN_W'(reassigned);
			o_iter_q    <= iterations;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_W'({o_iter_q, o_reas_q, o_cval_q, o_cluster_q, o_status_q});

	// A word is only taken while the engine is idle.
	assert property (@(posedge clk) disable iff (!arst_n) accept |-> !stat.busy)
		else $error("input word taken while the engine runs");

	// The engine reports completion only for a pending run.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (pend_q && (pkind_q == kmlt_pkg::KIND_RUN)))
		else $error("engine completion without a pending run");

	// A new result never overwrites one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n) cap |-> !out_v_q)
		else $error("result register overwritten");

endmodule
`default_nettype wire
